[rtl/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants for the escape-time counter
// Fixed-point formats, the word handed from cell to cell, saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

	// Q4.28 operands
	localparam int Q_W       = 32;
	localparam int FRAC_BITS = 28;
	// exact squares and products
	localparam int PROD_W    = 2 * Q_W;
	// width after scaling back and adding c
	localparam int SUM_W     = 38;
	// count and coordinate widths
	localparam int CNT_W     = 7;
	localparam int COORD_W   = 12;
	// coordinate shifted into Q4.28 before saturation
	localparam int CEXT_W    = 40;

	// 4.0 in Q8.56, compared against the 65-bit sum of squares
	localparam logic [PROD_W:0] ESCAPE_Q56 = (PROD_W + 1)'(1) << 58;
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(50);

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// word passed along the chain of cells
	typedef struct packed {
		logic valid;
		logic done;
		q_t   zr;
		q_t   zi;
		q_t   cr;
		q_t   ci;
		cnt_t count;
	} mec_word_t;

	// clamp a widened sum back to Q4.28
	function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
		logic ovf;
		ovf = (v[SUM_W-1:Q_W-1] != {(SUM_W-Q_W+1){1'b0}}) &&
			(v[SUM_W-1:Q_W-1] != {(SUM_W-Q_W+1){1'b1}});
		if (!ovf) begin
			return v[Q_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			return {1'b0, {(Q_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

[rtl/mandelbrot_escape_count.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_count: escape-time counter over a chain of iteration cells
//
// Input stream s_*: one word per pixel, col and row. c = (col, row) / 2^COORD_BITS
// in Q4.28, saturated just below 8.0. Output stream m_*: one word per pixel,
// the count of iterations run before |z|^2 exceeded 4, capped at
// min(iteration_limit, MAX_ITERATIONS).
// Throughput: one pixel per cycle while the output is not stalled. Each of the
// MAX_ITERATIONS cells does one iteration in two stages (multiply, then test and
// update), and an output register follows the last cell.
// Stall: the whole chain advances together; while the output word waits
// (m_tvalid high, m_tready low) the chain freezes and s_tready drops.
// Reset clears all valid bits and sets iteration_limit to 50.
// iteration_limit is written through cfg_wr_en / cfg_wr_data and must only
// change while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_count
	import mec_pkg::*;
#(
	parameter int COORD_BITS     = 12,
	parameter int MAX_ITERATIONS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [6:0]  cfg_wr_data,   // iteration_limit
	// pixel input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,       // [11:0] col, [23:12] row
	// count output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata        // [6:0] escape_count, [7] zero
);

	localparam int CSHIFT = FRAC_BITS - COORD_BITS;
	localparam logic [CEXT_W-1:0] CMAX = CEXT_W'({1'b0, {(Q_W-1){1'b1}}});

	// iteration limit register
	cnt_t limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// chain advances unless the output word is stuck
	logic en;
	logic out_valid_q;
	cnt_t count_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// coordinate mapping with saturation
	logic [CEXT_W-1:0] col_ext, row_ext;
	q_t                cr_in, ci_in;

	assign col_ext = CEXT_W'(s_tdata[COORD_W-1:0]) << CSHIFT;
	assign row_ext = CEXT_W'(s_tdata[2*COORD_W-1:COORD_W]) << CSHIFT;
	assign cr_in   = (col_ext > CMAX) ? CMAX[Q_W-1:0] : col_ext[Q_W-1:0];
	assign ci_in   = (row_ext > CMAX) ? CMAX[Q_W-1:0] : row_ext[Q_W-1:0];

	// chain of cells
	mec_word_t chain [MAX_ITERATIONS+1];

	always_comb begin
		chain[0].valid = s_tvalid;
		chain[0].done  = 1'b0;
		chain[0].zr    = '0;
		chain[0].zi    = '0;
		chain[0].cr    = cr_in;
		chain[0].ci    = ci_in;
		chain[0].count = '0;
	end

	for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_cell
		mec_cell #(
			.IDX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.limit    (limit_q),
			.word_in  (chain[k]),
			.word_out (chain[k+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[MAX_ITERATIONS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_q <= chain[MAX_ITERATIONS].count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, count_q};

`ifndef SYNTH
	// input side is held off only by a stalled output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("mec: input stalled without output backpressure");

	// a valid word in the last cell reaches the output when the chain advances
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		en && chain[MAX_ITERATIONS].valid |=> m_tvalid)
		else $error("mec: finished pixel lost at output");

	// a waiting output word holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("mec: output word changed while stalled");
`endif

endmodule

`default_nettype wire

[rtl/mec_cell.sv]
// ----------------------------------------------------------------------------
// mec_cell: one Mandelbrot iteration step
// Stage 1 forms zr^2, zi^2 and zr*zi; stage 2 runs the escape test and
// the update z <- z^2 + c with saturation. Words move on every enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_cell
	import mec_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire cnt_t      limit,
	input  wire mec_word_t word_in,
	output mec_word_t      word_out
);

	// iteration IDX runs only while the pixel is still live and below the limit
	logic active;
	assign active = word_in.valid && !word_in.done && (32'(limit) > IDX);

	// stage 1: products
	logic                     valid_s1, done_s1, active_s1;
	logic signed [PROD_W-1:0] a_s1, b_s1, p_s1;
	q_t                       zr_s1, zi_s1, cr_s1, ci_s1;
	cnt_t                     count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			done_s1   <= word_in.done;
			active_s1 <= active;
			a_s1      <= PROD_W'(word_in.zr) * PROD_W'(word_in.zr);
			b_s1      <= PROD_W'(word_in.zi) * PROD_W'(word_in.zi);
			p_s1      <= PROD_W'(word_in.zr) * PROD_W'(word_in.zi);
			zr_s1     <= word_in.zr;
			zi_s1     <= word_in.zi;
			cr_s1     <= word_in.cr;
			ci_s1     <= word_in.ci;
			count_s1  <= word_in.count;
		end
	end

	// stage 2: escape test and update
	logic [PROD_W:0]          mag2;
	logic                     escaped;
	logic signed [PROD_W-1:0] diff;
	logic signed [SUM_W-1:0]  nr, ni;

	assign mag2    = {1'b0, a_s1} + {1'b0, b_s1};
	assign escaped = mag2 > ESCAPE_Q56;
	assign diff    = a_s1 - b_s1;
	// arithmetic shifts floor toward minus infinity
	assign nr = SUM_W'(signed'(diff[PROD_W-1:FRAC_BITS])) + SUM_W'(cr_s1);
	assign ni = SUM_W'(signed'(p_s1[PROD_W-1:FRAC_BITS-1])) + SUM_W'(ci_s1);

	logic valid_s2, done_s2;
	q_t   zr_s2, zi_s2, cr_s2, ci_s2;
	cnt_t count_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s2 <= cr_s1;
			ci_s2 <= ci_s1;
			if (active_s1 && !escaped) begin
				done_s2  <= 1'b0;
				count_s2 <= count_s1 + cnt_t'(1);
				zr_s2    <= sat_q(nr);
				zi_s2    <= sat_q(ni);
			end else begin
				done_s2  <= 1'b1;
				count_s2 <= count_s1;
				zr_s2    <= zr_s1;
				zi_s2    <= zi_s1;
			end
		end
	end

	always_comb begin
		word_out.valid = valid_s2;
		word_out.done  = done_s2;
		word_out.zr    = zr_s2;
		word_out.zi    = zi_s2;
		word_out.cr    = cr_s2;
		word_out.ci    = ci_s2;
		word_out.count = count_s2;
	end

`ifndef SYNTH
	// a finished pixel stays finished through the cell
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && done_s1 |=> done_s2)
		else $error("mec_cell: done pixel revived");

	// an inactive pixel keeps its count
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && !active_s1 |=> count_s2 == $past(count_s1))
		else $error("mec_cell: inactive pixel count changed");

	// a live pixel past stage 2 has one more iteration counted
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && active_s1 && !escaped |=>
			count_s2 == $past(count_s1) + cnt_t'(1))
		else $error("mec_cell: live pixel count not advanced");
`endif

endmodule

`default_nettype wire
